FILE: rtl/trs_pkg.sv
// ----------------------------------------------------------------------------
// trs_pkg
// Shared types and constants of the tracker row sequencer: operation codes,
// event actions, table sizes and the row-length divider widths.
// ----------------------------------------------------------------------------
package trs_pkg;

    // Table sizes, fixed by the field widths of the command port
    localparam int TRACKS      = 8;
    localparam int CHANNELS    = 4;
    localparam int PATTERNS    = 16;
    localparam int ROWS        = 32;
    localparam int INSTRUMENTS = 16;
    localparam int TICK_RATE   = 60;

    localparam int ROW_FRAMES    = 6;
    localparam int DEFAULT_TEMPO = 20;

    // Row length in ticks before division by the tempo
    localparam int ROW_TICKS = ROW_FRAMES * TICK_RATE;
    localparam int QUO_W     = $clog2(ROW_TICKS + 1);
    localparam int STEP_W    = $clog2(QUO_W);

    localparam int TRK_W  = $clog2(TRACKS);
    localparam int CH_W   = $clog2(CHANNELS);
    localparam int PAT_W  = $clog2(PATTERNS);
    localparam int ROW_W  = $clog2(ROWS);
    localparam int INS_W  = $clog2(INSTRUMENTS);
    localparam int SLOT_W = $clog2(PATTERNS + 1);

    localparam int NOTE_ADDR_W = TRK_W + PAT_W + ROW_W;
    localparam int NOTE_DEPTH  = TRACKS * PATTERNS * ROWS;
    localparam int MAP_DEPTH   = TRACKS * CHANNELS;

    // Command codes
    typedef enum logic [2:0] {
        OP_TICK      = 3'd0,
        OP_PLAY      = 3'd1,
        OP_STOP      = 3'd2,
        OP_WR_NOTE   = 3'd3,
        OP_WR_MAP    = 3'd4,
        OP_WR_TEMPO  = 3'd5,
        OP_WR_INSTR  = 3'd6,
        OP_NONE      = 3'd7
    } t_op;

    // Event actions
    localparam logic ACT_STOP = 1'b0;
    localparam logic ACT_PLAY = 1'b1;

endpackage

FILE: rtl/tracker_row_sequencer.sv
// ----------------------------------------------------------------------------
// tracker_row_sequencer
// Pattern sequencer: holds tempos, channel maps, pattern notes and an
// instrument map, and turns frame ticks into per-channel note events.
// ----------------------------------------------------------------------------
// Usage:
//   Commands enter on start/busy: a command transfers at a rising edge with
//   start high and busy low. Writes, play, idle ticks and row-counter ticks
//   leave busy low. A tick that ends a row before the last runs a restoring
//   divider for the row length (360 / tempo), then scans the channels up to
//   the last mapped one, one map lookup per cycle and a note-memory read
//   per mapped channel; events pass the registered memory read and the
//   output register. A row step holds busy through the divider, the scan
//   and the last note read. Stop emits four stop events, one per cycle, via
//   ST_STOP and the output register. Events appear on the o_ result ports
//   for one cycle with o_strobe high; o_last marks the final event of a
//   command. The receiver cannot stall. The user must write stop_note_code
//   through i_cfg_we/i_cfg_data only while idle; the block does not enforce
//   this. Reset clears playback state, sets every tempo to 20 and empties
//   all channel maps. Note memory and instrument map are not cleared.
// ----------------------------------------------------------------------------
module tracker_row_sequencer (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    input  logic [2:0]        i_operation,
    input  logic [2:0]        i_track_index,
    input  logic [1:0]        i_channel_index,
    input  logic [4:0]        i_pattern_slot,
    input  logic [4:0]        i_row_index,
    input  logic [7:0]        i_note_value,
    input  logic [3:0]        i_instrument_slot,
    input  logic [7:0]        i_table_value,
    input  logic              i_cfg_we,
    input  logic [7:0]        i_cfg_data,
    output logic              o_strobe,
    output logic [1:0]        o_channel,
    output logic              o_action,
    output logic [7:0]        o_instrument_id,
    output logic [7:0]        o_note,
    output logic              o_last,
    output logic              o_playing,
    output logic [2:0]        o_current_track,
    output logic signed [5:0] o_current_row
);

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_DIV  = 4'b0010,
        ST_SCAN = 4'b0100,
        ST_STOP = 4'b1000
    } t_state;

    t_state r_state;

    // Playback state and tables
    logic [7:0]                    r_stop_code;
    logic                          r_playing;
    logic [trs_pkg::TRK_W-1:0]     r_track;
    logic signed [5:0]             r_row;
    logic [trs_pkg::QUO_W-1:0]     r_ticks;
    logic [7:0]                    r_tempo [trs_pkg::TRACKS];
    logic [trs_pkg::SLOT_W-1:0]    r_chmap [trs_pkg::MAP_DEPTH];
    logic [7:0]                    r_inst_map [trs_pkg::INSTRUMENTS];

    // Note memory, one read and one write port
    logic [11:0] r_note_mem [trs_pkg::NOTE_DEPTH];
    logic [11:0] r_mem_q;
    logic        w_mem_we;
    logic [trs_pkg::NOTE_ADDR_W-1:0] w_mem_waddr;
    logic [trs_pkg::NOTE_ADDR_W-1:0] w_mem_raddr;

    // Divider
    logic [trs_pkg::QUO_W-1:0]  r_quo;
    logic [7:0]                 r_rem;
    logic [7:0]                 r_divisor;
    logic [trs_pkg::STEP_W-1:0] r_div_cnt;
    logic [8:0]                 w_shift;
    logic                       w_qbit;
    logic [trs_pkg::QUO_W-1:0]  w_quo_nx;
    logic [7:0]                 w_rem_nx;

    // Channel scan
    logic [trs_pkg::CH_W-1:0]     r_ch;
    logic [trs_pkg::CHANNELS-1:0] w_mask;
    logic                         w_more;
    logic [trs_pkg::SLOT_W-1:0]   w_slot;
    logic [trs_pkg::SLOT_W-1:0]   w_pat;
    logic                         r_rd_valid;
    logic [trs_pkg::CH_W-1:0]     r_rd_ch;
    logic                         r_rd_last;

    logic   w_accept;

    trs_pkg::t_op w_op;

    assign w_accept = start && !busy;
    assign busy     = (r_state != ST_IDLE) || r_rd_valid;
    assign w_op     = trs_pkg::t_op'(i_operation);

    // Divider step: shift in the next dividend bit, subtract when it fits
    assign w_shift  = {r_rem, r_quo[trs_pkg::QUO_W-1]};
    assign w_qbit   = (w_shift >= {1'b0, r_divisor});
    assign w_rem_nx = w_qbit ? 8'(w_shift - {1'b0, r_divisor}) : w_shift[7:0];
    assign w_quo_nx = {r_quo[trs_pkg::QUO_W-2:0], w_qbit};

    // Which channels of the current track have a pattern
    always_comb begin
        for (int i = 0; i < trs_pkg::CHANNELS; i++) begin
            w_mask[i] = (r_chmap[{r_track, trs_pkg::CH_W'(i)}] != '0);
        end
    end

    // Any channel above the one being scanned still to read
    always_comb begin
        w_more = 1'b0;
        for (int i = 0; i < trs_pkg::CHANNELS; i++) begin
            if ((trs_pkg::CH_W+1)'(i) > {1'b0, r_ch} && w_mask[i]) begin
                w_more = 1'b1;
            end
        end
    end

    assign w_slot      = r_chmap[{r_track, r_ch}];
    assign w_pat       = w_slot - trs_pkg::SLOT_W'(1);
    assign w_mem_raddr = {r_track, w_pat[trs_pkg::PAT_W-1:0], r_row[trs_pkg::ROW_W-1:0]};
    assign w_mem_we    = w_accept && (w_op == trs_pkg::OP_WR_NOTE)
                         && ({1'b0, i_pattern_slot} < 6'(trs_pkg::PATTERNS));
    assign w_mem_waddr = {i_track_index, i_pattern_slot[trs_pkg::PAT_W-1:0], i_row_index};

    // Note memory
    always_ff @(posedge i_clk) begin
        if (w_mem_we) begin
            r_note_mem[w_mem_waddr] <= {i_instrument_slot, i_note_value};
        end
        r_mem_q <= r_note_mem[w_mem_raddr];
    end

    // Instrument map, written only by commands
    always_ff @(posedge i_clk) begin
        if (w_accept && w_op == trs_pkg::OP_WR_INSTR) begin
            r_inst_map[i_instrument_slot] <= i_table_value;
        end
    end

    // Configuration register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stop_code <= 8'hFF;
        end else if (i_cfg_we) begin
            r_stop_code <= i_cfg_data;
        end
    end

    // Tempo table and channel map
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < trs_pkg::TRACKS; i++) begin
                r_tempo[i] <= 8'(trs_pkg::DEFAULT_TEMPO);
            end
            for (int i = 0; i < trs_pkg::MAP_DEPTH; i++) begin
                r_chmap[i] <= '0;
            end
        end else if (w_accept) begin
            if (w_op == trs_pkg::OP_WR_TEMPO) begin
                r_tempo[i_track_index] <= (i_table_value == 8'd0) ? 8'd1 : i_table_value;
            end
            if (w_op == trs_pkg::OP_WR_MAP
                && {1'b0, i_pattern_slot} <= 6'(trs_pkg::PATTERNS)) begin
                r_chmap[{i_track_index, i_channel_index}] <= i_pattern_slot;
            end
        end
    end

    // Sequencer control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_IDLE;
            r_playing  <= 1'b0;
            r_track    <= '0;
            r_row      <= '0;
            r_ticks    <= '0;
            r_ch       <= '0;
            r_div_cnt  <= '0;
            r_rd_valid <= 1'b0;
        end else begin
            r_rd_valid <= 1'b0;
            unique case (r_state)
                ST_IDLE: begin
                    if (w_accept) begin
                        case (w_op)
                            trs_pkg::OP_TICK: begin
                                if (r_playing && r_ticks != '0) begin
                                    r_ticks <= r_ticks - trs_pkg::QUO_W'(1);
                                end else if (r_playing) begin
                                    if (r_row == 6'(trs_pkg::ROWS - 1)) begin
                                        // past the last row: end silently
                                        r_row     <= '0;
                                        r_playing <= 1'b0;
                                    end else begin
                                        r_row     <= r_row + 6'sd1;
                                        r_quo     <= trs_pkg::QUO_W'(trs_pkg::ROW_TICKS);
                                        r_rem     <= '0;
                                        r_divisor <= r_tempo[r_track];
                                        r_div_cnt <= '0;
                                        r_state   <= ST_DIV;
                                    end
                                end
                            end
                            trs_pkg::OP_PLAY: begin
                                r_playing <= 1'b1;
                                r_track   <= i_track_index;
                                r_row     <= -6'sd1;
                                r_ticks   <= '0;
                            end
                            trs_pkg::OP_STOP: begin
                                r_playing <= 1'b0;
                                r_ch      <= '0;
                                r_state   <= ST_STOP;
                            end
                            default: begin
                            end
                        endcase
                    end
                end
                ST_DIV: begin
                    r_rem     <= w_rem_nx;
                    r_quo     <= w_quo_nx;
                    r_div_cnt <= r_div_cnt + trs_pkg::STEP_W'(1);
                    if (r_div_cnt == trs_pkg::STEP_W'(trs_pkg::QUO_W - 1)) begin
                        // counter holds one less than the row length
                        r_ticks <= (w_quo_nx == '0) ? '0 : w_quo_nx - trs_pkg::QUO_W'(1);
                        r_ch    <= '0;
                        r_state <= ST_SCAN;
                    end
                end
                ST_SCAN: begin
                    if (w_mask[r_ch]) begin
                        r_rd_valid <= 1'b1;
                    end
                    r_ch <= r_ch + trs_pkg::CH_W'(1);
                    if (r_ch == trs_pkg::CH_W'(trs_pkg::CHANNELS - 1) || !w_more) begin
                        r_state <= ST_IDLE;
                    end
                end
                ST_STOP: begin
                    r_ch <= r_ch + trs_pkg::CH_W'(1);
                    if (r_ch == trs_pkg::CH_W'(trs_pkg::CHANNELS - 1)) begin
                        r_state <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    // Read tag travels with the memory read
    always_ff @(posedge i_clk) begin
        r_rd_ch   <= r_ch;
        r_rd_last <= !w_more;
    end

    // Event output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_strobe <= 1'b0;
        end else begin
            o_strobe <= r_rd_valid || (r_state == ST_STOP);
        end
    end

    always_ff @(posedge i_clk) begin
        o_playing       <= r_playing;
        o_current_track <= r_track;
        o_current_row   <= r_row;
        if (r_state == ST_STOP) begin
            o_channel       <= r_ch;
            o_action        <= trs_pkg::ACT_STOP;
            o_instrument_id <= 8'd0;
            o_note          <= 8'd0;
            o_last          <= (r_ch == trs_pkg::CH_W'(trs_pkg::CHANNELS - 1));
        end else begin
            o_channel <= r_rd_ch;
            o_last    <= r_rd_last;
            if (r_mem_q[7:0] == r_stop_code) begin
                o_action        <= trs_pkg::ACT_STOP;
                o_instrument_id <= 8'd0;
                o_note          <= 8'd0;
            end else begin
                o_action        <= trs_pkg::ACT_PLAY;
                o_instrument_id <= r_inst_map[r_mem_q[11:8]];
                o_note          <= r_mem_q[7:0];
            end
        end
    end

`ifndef SYNTHESIS
    // An event only follows a cycle in which the block was busy
    a_strobe_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> $past(busy))
        else $error("event without preceding busy cycle");

    // A note read is only issued from the channel scan
    a_read_from_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_rd_valid |-> $past(r_state == ST_SCAN))
        else $error("note read outside channel scan");

    // The final event of a command releases busy
    a_last_frees_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_last) |-> !busy)
        else $error("busy still high on final event");

    // Play events only happen during playback
    a_play_while_playing: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_action == trs_pkg::ACT_PLAY) |-> o_playing)
        else $error("play event while stopped");
`endif

endmodule

FILE: tb/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the tracker row sequencer. Commands go in over the
// start/busy handshake and are mirrored into a behavioral sequencer model.
// Every transfer queues the note events it should cause. A monitor compares
// each strobed event field by field against the oldest queued event.
// Directed tests cover the table writes, playback, the end of a track, the
// tempo clamp and stop handling. Short random sessions then follow, under
// several stop codes and sender idle rates.
// ----------------------------------------------------------------------------
module tb_top;

    // One command as presented on the input ports
    typedef struct {
        trs_pkg::t_op op;
        logic [2:0]   trk;
        logic [1:0]   chn;
        logic [4:0]   slot;
        logic [4:0]   row;
        logic [7:0]   note;
        logic [3:0]   ins;
        logic [7:0]   value;
    } t_command;

    // One note event as seen on the result ports
    typedef struct {
        logic [1:0] channel;
        logic       action;
        logic [7:0] instrument_id;
        logic [7:0] note;
        logic       last;
        logic       playing;
        logic [2:0] track;
        logic [5:0] row;
    } t_note_event;

    // DUT connections, all inputs known from time zero
    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              start = 1'b0;
    logic              busy;
    logic [2:0]        i_operation = '0;
    logic [2:0]        i_track_index = '0;
    logic [1:0]        i_channel_index = '0;
    logic [4:0]        i_pattern_slot = '0;
    logic [4:0]        i_row_index = '0;
    logic [7:0]        i_note_value = '0;
    logic [3:0]        i_instrument_slot = '0;
    logic [7:0]        i_table_value = '0;
    logic              i_cfg_we = 1'b0;
    logic [7:0]        i_cfg_data = '0;
    logic              o_strobe;
    logic [1:0]        o_channel;
    logic              o_action;
    logic [7:0]        o_instrument_id;
    logic [7:0]        o_note;
    logic              o_last;
    logic              o_playing;
    logic [2:0]        o_current_track;
    logic signed [5:0] o_current_row;

    // Sequencer model state
    bit          seq_playing;
    bit [2:0]    seq_track;
    int          seq_row;
    int          seq_ticks;
    bit [7:0]    tempo_tbl [trs_pkg::TRACKS];
    bit [4:0]    slot_map [trs_pkg::MAP_DEPTH];
    bit [11:0]   note_mem [trs_pkg::NOTE_DEPTH];
    bit          note_valid [trs_pkg::NOTE_DEPTH];
    bit [7:0]    instr_tbl [trs_pkg::INSTRUMENTS];
    bit [7:0]    stop_code;

    t_note_event due_events [$];
    int          error_count = 0;
    int          idle_pct = 0;

    tracker_row_sequencer uut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .start             (start),
        .busy              (busy),
        .i_operation       (i_operation),
        .i_track_index     (i_track_index),
        .i_channel_index   (i_channel_index),
        .i_pattern_slot    (i_pattern_slot),
        .i_row_index       (i_row_index),
        .i_note_value      (i_note_value),
        .i_instrument_slot (i_instrument_slot),
        .i_table_value     (i_table_value),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_data        (i_cfg_data),
        .o_strobe          (o_strobe),
        .o_channel         (o_channel),
        .o_action          (o_action),
        .o_instrument_id   (o_instrument_id),
        .o_note            (o_note),
        .o_last            (o_last),
        .o_playing         (o_playing),
        .o_current_track   (o_current_track),
        .o_current_row     (o_current_row)
    );

    // 10 time unit clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Sequencer model
    // ------------------------------------------------------------------
    function automatic void reset_sequencer_model();
        seq_playing = 1'b0;
        seq_track   = '0;
        seq_row     = 0;
        seq_ticks   = 0;
        stop_code   = 8'hFF;
        foreach (tempo_tbl[i]) tempo_tbl[i] = 8'(trs_pkg::DEFAULT_TEMPO);
        foreach (slot_map[i]) slot_map[i] = '0;
        foreach (note_valid[i]) note_valid[i] = 1'b0;
    endfunction

    // Apply one accepted command and queue the events it causes
    function automatic void step_sequencer(t_command c);
        t_note_event batch [$];
        t_note_event ev;
        int          idx;
        int          slot;
        bit [11:0]   entry;
        case (c.op)
            trs_pkg::OP_TICK: begin
                if (seq_playing) begin
                    if (seq_ticks == 0) begin
                        seq_row++;
                        if (seq_row >= trs_pkg::ROWS) begin
                            // ran off the last row: stop quietly
                            seq_row     = 0;
                            seq_playing = 1'b0;
                        end else begin
                            seq_ticks = trs_pkg::ROW_TICKS / int'(tempo_tbl[seq_track]);
                            for (int ch = 0; ch < trs_pkg::CHANNELS; ch++) begin
                                slot = int'(slot_map[int'(seq_track) * trs_pkg::CHANNELS + ch]);
                                if (slot != 0) begin
                                    idx = (int'(seq_track) * trs_pkg::PATTERNS + slot - 1)
                                          * trs_pkg::ROWS + seq_row;
                                    entry = note_mem[idx];
                                    ev.channel = 2'(ch);
                                    ev.last    = 1'b0;
                                    ev.playing = 1'b1;
                                    ev.track   = seq_track;
                                    ev.row     = seq_row[5:0];
                                    if (entry[7:0] == stop_code) begin
                                        ev.action        = trs_pkg::ACT_STOP;
                                        ev.instrument_id = '0;
                                        ev.note          = '0;
                                    end else begin
                                        ev.action        = trs_pkg::ACT_PLAY;
                                        ev.instrument_id = instr_tbl[entry[11:8]];
                                        ev.note          = entry[7:0];
                                    end
                                    batch.push_back(ev);
                                end
                            end
                        end
                    end
                    if (seq_playing && seq_ticks > 0) seq_ticks--;
                end
            end
            trs_pkg::OP_PLAY: begin
                seq_playing = 1'b1;
                seq_track   = c.trk;
                seq_row     = -1;
                seq_ticks   = 0;
            end
            trs_pkg::OP_STOP: begin
                seq_playing = 1'b0;
                for (int ch = 0; ch < trs_pkg::CHANNELS; ch++) begin
                    ev.channel       = 2'(ch);
                    ev.action        = trs_pkg::ACT_STOP;
                    ev.instrument_id = '0;
                    ev.note          = '0;
                    ev.last          = 1'b0;
                    ev.playing       = 1'b0;
                    ev.track         = seq_track;
                    ev.row           = seq_row[5:0];
                    batch.push_back(ev);
                end
            end
            trs_pkg::OP_WR_NOTE: begin
                if (c.slot < trs_pkg::PATTERNS) begin
                    idx = (int'(c.trk) * trs_pkg::PATTERNS + int'(c.slot)) * trs_pkg::ROWS
                          + int'(c.row);
                    note_mem[idx]   = {c.ins, c.note};
                    note_valid[idx] = 1'b1;
                end
            end
            trs_pkg::OP_WR_MAP: begin
                if (c.slot <= trs_pkg::PATTERNS)
                    slot_map[int'(c.trk) * trs_pkg::CHANNELS + int'(c.chn)] = c.slot;
            end
            trs_pkg::OP_WR_TEMPO: begin
                tempo_tbl[c.trk] = (c.value == 8'd0) ? 8'd1 : c.value;
            end
            trs_pkg::OP_WR_INSTR: begin
                instr_tbl[c.ins] = c.value;
            end
            default: ;
        endcase
        if (batch.size() > 0) batch[batch.size() - 1].last = 1'b1;
        foreach (batch[i]) due_events.push_back(batch[i]);
    endfunction

    // Next tick would read a note entry that was never written
    function automatic bit tick_reads_unwritten();
        int nxt;
        int slot;
        int idx;
        bit hit;
        hit = 1'b0;
        nxt = seq_row + 1;
        if (seq_playing && seq_ticks == 0 && nxt < trs_pkg::ROWS) begin
            for (int ch = 0; ch < trs_pkg::CHANNELS; ch++) begin
                slot = int'(slot_map[int'(seq_track) * trs_pkg::CHANNELS + ch]);
                if (slot != 0) begin
                    idx = (int'(seq_track) * trs_pkg::PATTERNS + slot - 1) * trs_pkg::ROWS
                          + nxt;
                    if (!note_valid[idx]) hit = 1'b1;
                end
            end
        end
        return hit;
    endfunction

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    function automatic t_command random_command(trs_pkg::t_op op);
        t_command c;
        c.op    = op;
        c.trk   = 3'($urandom_range(0, 7));
        c.chn   = 2'($urandom_range(0, 3));
        c.slot  = 5'($urandom_range(0, 31));
        c.row   = 5'($urandom_range(0, 31));
        c.note  = 8'($urandom_range(0, 255));
        c.ins   = 4'($urandom_range(0, 15));
        c.value = 8'($urandom_range(0, 255));
        return c;
    endfunction

    // Present one command, hold it until the transfer, then predict
    task automatic issue_command(t_command c);
        int gap;
        gap = ($urandom_range(0, 99) < idle_pct) ? $urandom_range(1, 4) : 0;
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start             <= 1'b1;
        i_operation       <= c.op;
        i_track_index     <= c.trk;
        i_channel_index   <= c.chn;
        i_pattern_slot    <= c.slot;
        i_row_index       <= c.row;
        i_note_value      <= c.note;
        i_instrument_slot <= c.ins;
        i_table_value     <= c.value;
        do @(posedge i_clk); while (busy !== 1'b0);
        step_sequencer(c);
    endtask

    // Tick, or stop instead when the next row is not written on a mapped channel
    task automatic send_tick();
        if (tick_reads_unwritten())
            issue_command(random_command(trs_pkg::OP_STOP));
        else
            issue_command(random_command(trs_pkg::OP_TICK));
    endtask

    // Wait for all queued events, then let a silent row step finish
    task automatic settle_sequencer();
        int waited;
        start <= 1'b0;
        waited = 0;
        while (due_events.size() > 0 && waited < 4000) begin
            @(posedge i_clk);
            waited++;
        end
        if (due_events.size() > 0) begin
            $display("%0t: expected %0d more events, actual none",
                     $time, due_events.size());
            error_count++;
            due_events.delete();
        end
        repeat (24) @(posedge i_clk);
    endtask

    task automatic write_stop_code(logic [7:0] code);
        settle_sequencer();
        i_cfg_we   <= 1'b1;
        i_cfg_data <= code;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        stop_code = code;
    endtask

    task automatic send_map(int trk, int ch, int slot);
        t_command c;
        c      = random_command(trs_pkg::OP_WR_MAP);
        c.trk  = 3'(trk);
        c.chn  = 2'(ch);
        c.slot = 5'(slot);
        issue_command(c);
    endtask

    task automatic send_tempo(int trk, int tempo);
        t_command c;
        c       = random_command(trs_pkg::OP_WR_TEMPO);
        c.trk   = 3'(trk);
        c.value = 8'(tempo);
        issue_command(c);
    endtask

    task automatic send_play(int trk);
        t_command c;
        c     = random_command(trs_pkg::OP_PLAY);
        c.trk = 3'(trk);
        issue_command(c);
    endtask

    // Write the leading rows of one pattern, with the note extremes sprinkled in
    task automatic fill_pattern(int trk, int pat, int rows);
        t_command c;
        for (int r = 0; r < rows; r++) begin
            c      = random_command(trs_pkg::OP_WR_NOTE);
            c.trk  = 3'(trk);
            c.slot = 5'(pat);
            c.row  = 5'(r);
            case ($urandom_range(0, 7))
                0: c.note = 8'h00;
                1: c.note = 8'hFF;
                default: ;
            endcase
            issue_command(c);
        end
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Commands while stopped: stop still reports every channel
    task automatic test_idle_commands();
        issue_command(random_command(trs_pkg::OP_STOP));
        issue_command(random_command(trs_pkg::OP_TICK));
        issue_command(random_command(trs_pkg::OP_NONE));
    endtask

    // Fill the whole instrument map so no play event reads an empty slot
    task automatic test_instrument_map();
        t_command c;
        for (int i = 0; i < trs_pkg::INSTRUMENTS; i++) begin
            c     = random_command(trs_pkg::OP_WR_INSTR);
            c.ins = 4'(i);
            if (i == 0) c.value = 8'h00;
            else if (i == trs_pkg::INSTRUMENTS - 1) c.value = 8'hFF;
            issue_command(c);
        end
    endtask

    // Patterns, channel maps and tempos for the playback tests
    task automatic test_pattern_tables();
        t_command c;
        fill_pattern(0, 0, 8);
        fill_pattern(0, trs_pkg::PATTERNS - 1, 8);
        // pattern number out of range: dropped
        c      = random_command(trs_pkg::OP_WR_NOTE);
        c.slot = 5'($urandom_range(trs_pkg::PATTERNS, 31));
        issue_command(c);
        send_map(0, 0, 1);
        send_map(0, 2, 1);
        send_map(0, 3, trs_pkg::PATTERNS);
        send_map(0, 1, 20);         // slot above range: dropped
        send_tempo(0, 255);
        send_tempo(3, 255);
    endtask

    // Play rows 0 to 5 of track 0 under both stop code extremes, then stop
    task automatic test_full_playback();
        for (int k = 0; k < 2; k++) begin
            write_stop_code(k == 0 ? 8'h00 : 8'hFF);
            send_play(0);
            repeat (6) send_tick();
            issue_command(random_command(trs_pkg::OP_STOP));
        end
    endtask

    // An unmapped track runs past its last row and stops without events
    task automatic test_track_end();
        int guard;
        send_play(3);
        guard = 0;
        while (seq_playing && guard < 64) begin
            send_tick();
            guard++;
        end
        // a tick after the end must stay silent
        send_tick();
    endtask

    // Tempo 0 is stored as 1: the row after row 0 is 360 ticks away
    task automatic test_tempo_clamp();
        send_tempo(0, 0);
        send_play(0);
        repeat (3) send_tick();
        issue_command(random_command(trs_pkg::OP_STOP));
        send_tempo(0, 255);
    endtask

    // Short random sessions, mostly over two tracks, in four phases under three idle rates
    task automatic test_random_sessions();
        t_command c;
        int       pct [4];
        int       busy_tracks [2];
        int       r;
        int       n;
        pct         = '{0, 48, 0, 24};
        busy_tracks = '{0, 3};
        for (int ph = 0; ph < 4; ph++) begin
            // stop code: either a note that really occurs, or anything
            if ($urandom_range(0, 1))
                write_stop_code(note_mem[$urandom_range(0, 7)][7:0]);
            else
                write_stop_code(8'($urandom_range(0, 255)));
            idle_pct = pct[ph];
            for (int s = 0; s < 4; s++) begin
                r = $urandom_range(0, 99);
                if (r < 45) begin
                    n = $urandom_range(1, 3);
                    repeat (n) send_tick();
                end else if (r < 55) begin
                    c = random_command(trs_pkg::OP_WR_NOTE);
                    if ($urandom_range(0, 4) == 0) c.note = stop_code;
                    issue_command(c);
                end else if (r < 63) begin
                    c = random_command(trs_pkg::OP_WR_MAP);
                    if ($urandom_range(0, 9) < 7)
                        c.trk = 3'(busy_tracks[$urandom_range(0, 1)]);
                    c.slot = 5'($urandom_range(0, 20));
                    issue_command(c);
                end else if (r < 69) begin
                    c = random_command(trs_pkg::OP_WR_TEMPO);
                    c.value = 8'(($urandom_range(0, 29) == 0) ? 0 : $urandom_range(40, 255));
                    issue_command(c);
                end else if (r < 73) begin
                    issue_command(random_command(trs_pkg::OP_WR_INSTR));
                end else if (r < 82) begin
                    c = random_command(trs_pkg::OP_PLAY);
                    if ($urandom_range(0, 3) != 0)
                        c.trk = 3'(busy_tracks[$urandom_range(0, 1)]);
                    issue_command(c);
                end else if (r < 87) begin
                    issue_command(random_command(trs_pkg::OP_STOP));
                end else begin
                    issue_command(random_command(trs_pkg::OP_NONE));
                end
            end
        end
        idle_pct = 0;
    endtask

    // ------------------------------------------------------------------
    // Result monitor
    // ------------------------------------------------------------------
    function automatic void compare_field(string name, logic [7:0] expected_val,
                                          logic [7:0] actual_val);
        if (actual_val !== expected_val) begin
            $display("%0t: %s mismatch: expected %0h actual %0h",
                     $time, name, expected_val, actual_val);
            error_count++;
        end
    endfunction

    always @(posedge i_clk) begin : event_check
        t_note_event want;
        if (i_rst_n && o_strobe !== 1'b0) begin
            if (due_events.size() == 0) begin
                $display("%0t: event mismatch: expected none actual ch %0d action %0h note %0h",
                         $time, o_channel, o_action, o_note);
                error_count++;
            end else begin
                want = due_events.pop_front();
                compare_field("channel", 8'(want.channel), 8'(o_channel));
                compare_field("action", 8'(want.action), 8'(o_action));
                compare_field("instrument_id", want.instrument_id, o_instrument_id);
                compare_field("note", want.note, o_note);
                compare_field("last", 8'(want.last), 8'(o_last));
                compare_field("playing", 8'(want.playing), 8'(o_playing));
                compare_field("current_track", 8'(want.track), 8'(o_current_track));
                compare_field("current_row", 8'(want.row), 8'($unsigned(o_current_row)));
            end
        end
    end

    // ------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------
    initial begin
        reset_sequencer_model();
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_idle_commands();
        test_instrument_map();
        test_pattern_tables();
        test_full_playback();
        test_track_end();
        test_tempo_clamp();
        test_random_sessions();
        settle_sequencer();
        if (error_count == 0)
            $display("tb_top: PASS");
        else
            $display("tb_top: FAIL");
        $finish;
    end

    // Watchdog
    initial begin
        #3000000;
        $display("tb_top: FAIL");
        $finish;
    end

endmodule
